// ===== sv/shelf_rect_allocator_assert.svh =====
// assertion macros for the shelf rectangle allocator
// no dependencies; included by the top level only
`ifndef SHELF_RECT_ALLOCATOR_ASSERT_SVH
`define SHELF_RECT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SRA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("shelf_rect_allocator: assertion failed");
// next-cycle implication
`define SRA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("shelf_rect_allocator: assertion failed");
`else
`define SRA_ASSERT_NOW(label, clk, rst, ante, cons)
`define SRA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/sra_pkg.sv =====
// shared types, constants and codes of the shelf rectangle allocator
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package sra_pkg;

   localparam int DEF_MAX_SHELVES = 64;
   localparam int CSR_W           = 13;
   localparam int CSR_IDX_W       = 1;

   localparam logic [CSR_W-1:0] ATLAS_RESET = 13'd1024;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_HEIGHT = 1'b1;

   // request codes
   localparam logic REQ_PLACE = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   typedef struct packed {
      logic       req_type;
      logic [9:0] rect_width;
      logic [9:0] rect_height;
   } shelf_req_type;

   typedef struct packed {
      logic        placed;
      logic [11:0] pos_x;
      logic [11:0] pos_y;
      logic        dirty;
      logic [12:0] dirty_left;
      logic [12:0] dirty_top;
      logic [12:0] dirty_right;
      logic [12:0] dirty_bottom;
   } shelf_rsp_type;

   typedef struct packed {
      logic [11:0] top;
      logic [11:0] height;
      logic [12:0] remaining;
   } shelf_entry_type;

   typedef struct packed {
      logic        flag;
      logic [12:0] left;
      logic [12:0] top;
      logic [12:0] right;
      logic [12:0] bottom;
   } dirty_rect_type;

   typedef struct packed {
      logic        grow;
      logic        flush;
      logic [11:0] x;
      logic [11:0] y;
      logic [9:0]  w;
      logic [9:0]  h;
   } dirty_ctrl_type;

endpackage

// ===== sv/sra_shelf_mem.sv =====
// shelf table: one write port, one read port with registered read data
// depends on sra_pkg for the entry type
`timescale 1ns / 1ps

module sra_shelf_mem #(
   parameter int  MAX_SHELVES = sra_pkg::DEF_MAX_SHELVES,
   localparam int IDX_W       = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [IDX_W-1:0]          wr_addr,
   input  sra_pkg::shelf_entry_type  wr_data,
   input  logic [IDX_W-1:0]          rd_addr,
   output sra_pkg::shelf_entry_type  rd_data
);
   import sra_pkg::*;

   shelf_entry_type mem_ff [MAX_SHELVES];
   shelf_entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sra_dirty.sv =====
// dirty rectangle tracker: grows on each placement, clears on flush
// depends on sra_pkg for the area and control types
`timescale 1ns / 1ps

module sra_dirty (
   input  logic                    clock,
   input  logic                    reset,
   input  sra_pkg::dirty_ctrl_type ctrl,
   input  logic [12:0]             atlas_width,
   input  logic [12:0]             atlas_height,
   output sra_pkg::dirty_rect_type cur,
   output sra_pkg::dirty_rect_type grown
);
   import sra_pkg::*;

   dirty_rect_type area_ff, area_in;
   logic [12:0]    x_ext, y_ext, x_end, y_end;

   // candidate rectangle after a placement at (x, y)
   always_comb begin
      x_ext        = {1'b0, ctrl.x};
      y_ext        = {1'b0, ctrl.y};
      x_end        = x_ext + {3'b000, ctrl.w};
      y_end        = y_ext + {3'b000, ctrl.h};
      grown.flag   = 1'b1;
      grown.left   = (x_ext < area_ff.left)   ? x_ext : area_ff.left;
      grown.top    = (y_ext < area_ff.top)    ? y_ext : area_ff.top;
      grown.right  = (x_end > area_ff.right)  ? x_end : area_ff.right;
      grown.bottom = (y_end > area_ff.bottom) ? y_end : area_ff.bottom;
   end

   // next area
   always_comb begin
      area_in = area_ff;
      if (ctrl.flush) begin
         area_in.flag   = 1'b0;
         area_in.left   = atlas_width;
         area_in.top    = atlas_height;
         area_in.right  = '0;
         area_in.bottom = '0;
      end else if (ctrl.grow) begin
         area_in = grown;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         area_ff.flag   <= 1'b0;
         area_ff.left   <= ATLAS_RESET;
         area_ff.top    <= ATLAS_RESET;
         area_ff.right  <= '0;
         area_ff.bottom <= '0;
      end else begin
         area_ff <= area_in;
      end
   end

   assign cur = area_ff;

endmodule

// ===== sv/shelf_rect_allocator.sv =====
// shelf rectangle allocator top level: control sequencer, registers, result port
// depends on sra_pkg, sra_shelf_mem, sra_dirty and shelf_rect_allocator_assert.svh
`timescale 1ns / 1ps
`include "shelf_rect_allocator_assert.svh"
//
// Usage
// - request channel: drive req_data and raise start while busy is low; that edge
//   is the transfer. A request is a place (width and height) or a flush.
// - result channel: exactly one result per request, shown on rsp_data for one
//   cycle with rsp_valid high. The receiver cannot stall it and must take it.
// - result timing: flush, too-wide place and place into an empty table give the
//   result in the cycle after the transfer. Otherwise shelves are read from the
//   shelf table one per cycle (one memory read port, registered data) in
//   opening order until one fits or the last one is examined, and the result
//   is registered. busy is low again in the cycle the result shows, so the next
//   request may transfer then.
// - configuration: csr_wr_en, csr_index, csr_wdata write atlas width (index 0)
//   or height (index 1) at once; write only while the block is idle.
// - reset (synchronous, active high) sets both registers to 1024, empties the
//   shelf table by clearing its count and clears the dirty area. No clearing
//   pass is run over the table.
//
module shelf_rect_allocator #(
   parameter int  MAX_SHELVES = sra_pkg::DEF_MAX_SHELVES,
   localparam int IDX_W       = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1,
   localparam int CNT_W       = $clog2(MAX_SHELVES + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  sra_pkg::shelf_req_type            req_data,
   output logic                              rsp_valid,
   output sra_pkg::shelf_rsp_type            rsp_data,
   input  logic                              csr_wr_en,
   input  logic [sra_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sra_pkg::CSR_W-1:0]         csr_wdata
);
   import sra_pkg::*;

   state_type       state_ff, state_in;
   shelf_req_type   req_ff, req_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [12:0]     base_ff, base_in;
   logic [12:0]     atlas_w_ff, atlas_h_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   shelf_rsp_type   rsp_data_ff, rsp_data_in;

   logic            accept;
   logic [9:0]      cur_w, cur_h;
   logic [10:0]     rw, rh;
   logic            too_wide, fit, last, room;
   logic [13:0]     new_bottom;

   logic            mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr, mem_rd_addr;
   shelf_entry_type mem_wr_data, ent;

   dirty_ctrl_type  dctl;
   dirty_rect_type  dcur, dgrown;
   logic            succ, fail;
   logic [11:0]     px, py;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         atlas_w_ff <= ATLAS_RESET;
         atlas_h_ff <= ATLAS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ATLAS_WIDTH:  atlas_w_ff <= csr_wdata;
            CSR_ATLAS_HEIGHT: atlas_h_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // padded size of the request being worked on
   always_comb begin
      cur_w      = (state_ff == S_IDLE) ? req_data.rect_width  : req_ff.rect_width;
      cur_h      = (state_ff == S_IDLE) ? req_data.rect_height : req_ff.rect_height;
      rw         = {1'b0, cur_w} + 11'd1;
      rh         = {1'b0, cur_h} + 11'd1;
      too_wide   = {2'b00, rw} > atlas_w_ff;
      fit        = ({2'b00, rw} <= ent.remaining) && ({1'b0, rh} <= ent.height);
      last       = (CNT_W'(idx_ff) + CNT_W'(1)) == cnt_ff;
      room       = cnt_ff < CNT_W'(MAX_SHELVES);
      new_bottom = {1'b0, base_ff} + {3'b000, rh};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_data.req_type == REQ_PLACE && !too_wide && cnt_ff != '0) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (fit || last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer outputs: table access, shelf bookkeeping, result
   always_comb begin
      req_in      = req_ff;
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      base_in     = base_ff;
      mem_rd_addr = '0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      succ        = 1'b0;
      fail        = 1'b0;
      px          = '0;
      py          = '0;
      dctl        = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               if (req_data.req_type == REQ_FLUSH) begin
                  dctl.flush = 1'b1;
               end else if (too_wide) begin
                  fail = 1'b1;
               end else if (cnt_ff == '0) begin
                  // first shelf opens at the top
                  if (atlas_h_ff > {2'b00, rh}) begin
                     mem_wr_en             = 1'b1;
                     mem_wr_data.top       = '0;
                     mem_wr_data.height    = {1'b0, rh};
                     mem_wr_data.remaining = atlas_w_ff - {2'b00, rw};
                     cnt_in                = CNT_W'(1);
                     base_in               = {2'b00, rh};
                     succ                  = 1'b1;
                  end else begin
                     fail = 1'b1;
                  end
               end else begin
                  mem_rd_addr = '0;
                  idx_in      = '0;
               end
            end
         end
         S_SCAN: begin
            if (fit) begin
               // first fit: take from the shelf's free part
               mem_wr_en             = 1'b1;
               mem_wr_addr           = idx_ff;
               mem_wr_data           = ent;
               mem_wr_data.remaining = ent.remaining - {2'b00, rw};
               px                    = 12'(atlas_w_ff - ent.remaining);
               py                    = ent.top;
               succ                  = 1'b1;
            end else if (last) begin
               // open a new shelf below the last one
               if (room && ({1'b0, atlas_h_ff} > new_bottom)) begin
                  mem_wr_en             = 1'b1;
                  mem_wr_addr           = cnt_ff[IDX_W-1:0];
                  mem_wr_data.top       = base_ff[11:0];
                  mem_wr_data.height    = {1'b0, rh};
                  mem_wr_data.remaining = atlas_w_ff - {2'b00, rw};
                  cnt_in                = cnt_ff + CNT_W'(1);
                  base_in               = {1'b0, base_ff[11:0]} + {2'b00, rh};
                  py                    = base_ff[11:0];
                  succ                  = 1'b1;
               end else begin
                  fail = 1'b1;
               end
            end else begin
               mem_rd_addr = idx_ff + IDX_W'(1);
               idx_in      = idx_ff + IDX_W'(1);
            end
         end
         default: begin
         end
      endcase
      dctl.grow = succ;
      dctl.x    = px;
      dctl.y    = py;
      dctl.w    = cur_w;
      dctl.h    = cur_h;
   end

   // result assembly
   always_comb begin
      rsp_valid_in              = succ || fail || dctl.flush;
      rsp_data_in.placed        = succ;
      rsp_data_in.pos_x         = px;
      rsp_data_in.pos_y         = py;
      rsp_data_in.dirty         = succ ? dgrown.flag   : dcur.flag;
      rsp_data_in.dirty_left    = succ ? dgrown.left   : dcur.left;
      rsp_data_in.dirty_top     = succ ? dgrown.top    : dcur.top;
      rsp_data_in.dirty_right   = succ ? dgrown.right  : dcur.right;
      rsp_data_in.dirty_bottom  = succ ? dgrown.bottom : dcur.bottom;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      base_ff     <= base_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   sra_shelf_mem #(
      .MAX_SHELVES (MAX_SHELVES)
   ) u_shelf_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (ent)
   );

   sra_dirty u_dirty (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (dctl),
      .atlas_width  (atlas_w_ff),
      .atlas_height (atlas_h_ff),
      .cur          (dcur),
      .grown        (dgrown)
   );

   // checks
   `SRA_ASSERT_NXT(a_flush_answers_next, clock, reset, accept && req_data.req_type == REQ_FLUSH, rsp_valid_ff && !rsp_data_ff.placed)
   `SRA_ASSERT_NOW(a_placed_marks_dirty, clock, reset, rsp_valid_ff && rsp_data_ff.placed, rsp_data_ff.dirty)
   `SRA_ASSERT_NOW(a_scan_needs_shelves, clock, reset, state_ff == S_SCAN, cnt_ff != '0)
   `SRA_ASSERT_NXT(a_result_frees_block, clock, reset, rsp_valid_in, state_ff == S_IDLE)

endmodule
